// ===== hw/rtl/xrdu_pkg.sv =====
// shared types, constants and sequencer states of the xoshiro random draw unit
`timescale 1ns / 1ps

package xrdu_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned HALF_W    = WORD_W / 2;
	localparam int unsigned RANGE_W   = 32;
	localparam int unsigned PROB_W    = 54;
	localparam int unsigned FRAC_W    = 53;
	localparam int unsigned DIV_W     = RANGE_W + 1;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

	typedef logic [1:0]                cmd_t;
	typedef logic [WORD_W-1:0]         word_t;
	typedef logic signed [RANGE_W-1:0] range_t;
	typedef logic [PROB_W-1:0]         prob_t;
	typedef logic [DIV_W-1:0]          span_t;

	// request codes
	localparam cmd_t CMD_RAW   = 2'd0;
	localparam cmd_t CMD_RANGE = 2'd1;
	localparam cmd_t CMD_BERN  = 2'd2;
	localparam cmd_t CMD_FRAC  = 2'd3;

	// splitmix64 constants
	localparam word_t GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam word_t MIX_A = 64'hBF58_476D_1CE4_E5B9;
	localparam word_t MIX_B = 64'h94D0_49BB_1331_11EB;

	// 2^32, the span of the high half of a draw
	localparam span_t SPAN_FULL = 33'h1_0000_0000;

	typedef enum logic [3:0] {
		ST_SEED_ADD,
		ST_SEED_MUL1,
		ST_SEED_MUL2,
		ST_IDLE,
		ST_DECODE,
		ST_LIMIT_GO,
		ST_LIMIT_WAIT,
		ST_DRAW_A,
		ST_DRAW_B,
		ST_USE,
		ST_MOD_WAIT,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/xrdu_if.sv =====
// request and response channel interfaces of the xoshiro random draw unit
`timescale 1ns / 1ps

interface xrdu_req_if;
	logic            valid;
	logic            ready;
	xrdu_pkg::cmd_t   cmd;
	xrdu_pkg::range_t range_low;
	xrdu_pkg::range_t range_high;
	xrdu_pkg::prob_t  probability;

	modport source (output valid, cmd, range_low, range_high, probability, input ready);
	modport sink (input valid, cmd, range_low, range_high, probability, output ready);
endinterface

interface xrdu_rsp_if;
	logic             valid;
	logic             ready;
	xrdu_pkg::word_t  word;
	xrdu_pkg::range_t int_value;
	logic             bit_value;
	logic             range_error;

	modport source (output valid, word, int_value, bit_value, range_error, input ready);
	modport sink (input valid, word, int_value, bit_value, range_error, output ready);
endinterface

// ===== hw/rtl/xoshiro_random_draw_unit.sv =====
// top level of the xoshiro256** random draw unit
// Serves one request at a time from a xoshiro256** generator of four 64-bit
// state words. After reset, and after every write of the seed register, the
// state is refilled with splitmix64 hashes of the seed, one word at a time:
// the seed steps by gamma, then two multiplies run on the shared iterative
// 64-bit multiplier, and no request is taken meanwhile. A certain Bernoulli
// outcome (probability 0 or 2^53 and above) and an inverted range consume
// no draw. An integer draw takes a fresh draw for each rejected one and
// makes two passes of the bit-serial divider (one for the rejection limit,
// one for the final modulo). The result sits in an output register, so the
// next transaction is accepted while the previous result waits to be taken.
`timescale 1ns / 1ps

module xoshiro_random_draw_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  xrdu_pkg::word_t cfg_wdata,
	xrdu_req_if.sink        req,
	xrdu_rsp_if.source      rsp
);

	localparam int unsigned RW = xrdu_pkg::RANGE_W;
	localparam int unsigned FW = xrdu_pkg::FRAC_W;
	localparam int unsigned PW = xrdu_pkg::PROB_W;
	localparam int unsigned WW = xrdu_pkg::WORD_W;

	// splitmix mixing shifts and xoshiro rotations
	localparam int unsigned SM_SH0 = 30;
	localparam int unsigned SM_SH1 = 27;
	localparam int unsigned SM_SH2 = 31;
	localparam int unsigned RES_ROT = 7;
	localparam int unsigned ST_ROT  = 45;
	localparam int unsigned T_SHIFT = 17;

	function automatic xrdu_pkg::word_t rotl(input xrdu_pkg::word_t v, input int unsigned n);
		rotl = (v << n) | (v >> (WW - n));
	endfunction

	xrdu_pkg::state_t state_q, state_d;

	// seeding
	xrdu_pkg::word_t base_q, base_sum;
	logic [1:0]      wk_q;

	// generator state
	xrdu_pkg::word_t gen_q [4];

	// request held while in flight
	xrdu_pkg::cmd_t   cmd_q;
	xrdu_pkg::range_t lo_q, hi_q;
	xrdu_pkg::prob_t  prob_q;
	xrdu_pkg::span_t  r_q, limit_q;

	// draw pipeline within the sequencer
	xrdu_pkg::word_t t5_q, draw_q, rot_w;

	// result being built, and the output register
	xrdu_pkg::word_t  res_word_q, out_word_q;
	xrdu_pkg::range_t res_int_q, out_int_q;
	logic             res_bit_q, res_err_q, out_bit_q, out_err_q;
	logic             out_valid_q;

	logic             slot_free, accept, inverted, reject;

	// shared units
	logic            mul_start, mul_done;
	xrdu_pkg::word_t mul_a, mul_b, mul_p;
	logic            div_start, div_done;
	xrdu_pkg::span_t div_dividend, div_divisor, div_rem;

	xrdu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	xrdu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign base_sum  = base_q + xrdu_pkg::GAMMA;
	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == xrdu_pkg::ST_IDLE) && !cfg_we;
	assign accept    = req.valid && req.ready;
	assign inverted  = hi_q < lo_q;
	// a high half at or above the limit would bias the modulo
	assign reject    = {1'b0, draw_q[WW-1:WW-RW]} >= limit_q;
	assign rot_w     = rotl(t5_q, RES_ROT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xrdu_pkg::ST_SEED_ADD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mul_start    = 1'b0;
		mul_a        = base_sum ^ (base_sum >> SM_SH0);
		mul_b        = xrdu_pkg::MIX_A;
		div_start    = 1'b0;
		div_dividend = xrdu_pkg::SPAN_FULL;
		div_divisor  = r_q;
		unique case (state_q)
			xrdu_pkg::ST_SEED_ADD: begin
				mul_start = 1'b1;
				state_d   = xrdu_pkg::ST_SEED_MUL1;
			end
			xrdu_pkg::ST_SEED_MUL1: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_p ^ (mul_p >> SM_SH1);
					mul_b     = xrdu_pkg::MIX_B;
					state_d   = xrdu_pkg::ST_SEED_MUL2;
				end
			end
			xrdu_pkg::ST_SEED_MUL2: begin
				if (mul_done) begin
					state_d = (&wk_q) ? xrdu_pkg::ST_IDLE : xrdu_pkg::ST_SEED_ADD;
				end
			end
			xrdu_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = xrdu_pkg::ST_DECODE;
				end
			end
			xrdu_pkg::ST_DECODE: begin
				unique case (cmd_q) inside
					xrdu_pkg::CMD_RAW, xrdu_pkg::CMD_FRAC: begin
						state_d = xrdu_pkg::ST_DRAW_A;
					end
					xrdu_pkg::CMD_BERN: begin
						// certain outcomes consume no draw
						if (prob_q == '0 || prob_q[PW-1]) begin
							state_d = xrdu_pkg::ST_DONE;
						end else begin
							state_d = xrdu_pkg::ST_DRAW_A;
						end
					end
					default: begin
						state_d = inverted ? xrdu_pkg::ST_DONE : xrdu_pkg::ST_LIMIT_GO;
					end
				endcase
			end
			xrdu_pkg::ST_LIMIT_GO: begin
				div_start = 1'b1;
				state_d   = xrdu_pkg::ST_LIMIT_WAIT;
			end
			xrdu_pkg::ST_LIMIT_WAIT: begin
				if (div_done) begin
					state_d = xrdu_pkg::ST_DRAW_A;
				end
			end
			xrdu_pkg::ST_DRAW_A: begin
				state_d = xrdu_pkg::ST_DRAW_B;
			end
			xrdu_pkg::ST_DRAW_B: begin
				state_d = xrdu_pkg::ST_USE;
			end
			xrdu_pkg::ST_USE: begin
				if (cmd_q == xrdu_pkg::CMD_RANGE) begin
					if (reject) begin
						state_d = xrdu_pkg::ST_DRAW_A;
					end else begin
						div_start    = 1'b1;
						div_dividend = {1'b0, draw_q[WW-1:WW-RW]};
						state_d      = xrdu_pkg::ST_MOD_WAIT;
					end
				end else begin
					state_d = xrdu_pkg::ST_DONE;
				end
			end
			xrdu_pkg::ST_MOD_WAIT: begin
				if (div_done) begin
					state_d = xrdu_pkg::ST_DONE;
				end
			end
			xrdu_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = xrdu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = xrdu_pkg::ST_SEED_ADD;
			end
		endcase
		// a seed write restarts the state fill
		if (cfg_we) begin
			state_d = xrdu_pkg::ST_SEED_ADD;
		end
	end

	// seed walk: base steps by gamma once per state word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			wk_q   <= 2'd0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
			wk_q   <= 2'd0;
		end else begin
			if (state_q == xrdu_pkg::ST_SEED_ADD) begin
				base_q <= base_sum;
			end
			if (state_q == xrdu_pkg::ST_SEED_MUL2 && mul_done) begin
				wk_q <= wk_q + 2'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			xrdu_pkg::ST_SEED_MUL2: begin
				if (mul_done) begin
					gen_q[wk_q] <= mul_p ^ (mul_p >> SM_SH2);
				end
			end
			xrdu_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q  <= req.cmd;
					lo_q   <= req.range_low;
					hi_q   <= req.range_high;
					prob_q <= req.probability;
				end
			end
			xrdu_pkg::ST_DECODE: begin
				res_word_q <= '0;
				res_int_q  <= '0;
				res_bit_q  <= (cmd_q == xrdu_pkg::CMD_BERN) && prob_q[PW-1];
				res_err_q  <= (cmd_q == xrdu_pkg::CMD_RANGE) && inverted;
				// range size, 1 to 2^32
				r_q        <= {hi_q[RW-1], hi_q} - {lo_q[RW-1], lo_q} + 33'd1;
			end
			xrdu_pkg::ST_LIMIT_WAIT: begin
				if (div_done) begin
					limit_q <= xrdu_pkg::SPAN_FULL - div_rem;
				end
			end
			xrdu_pkg::ST_DRAW_A: begin
				t5_q <= gen_q[1] + (gen_q[1] << 2);
			end
			xrdu_pkg::ST_DRAW_B: begin
				draw_q   <= rot_w + (rot_w << 3);
				gen_q[0] <= gen_q[0] ^ gen_q[3] ^ gen_q[1];
				gen_q[1] <= gen_q[1] ^ gen_q[2] ^ gen_q[0];
				gen_q[2] <= gen_q[2] ^ gen_q[0] ^ (gen_q[1] << T_SHIFT);
				gen_q[3] <= rotl(gen_q[3] ^ gen_q[1], ST_ROT);
			end
			xrdu_pkg::ST_USE: begin
				case (cmd_q)
					xrdu_pkg::CMD_RAW:  res_word_q <= draw_q;
					xrdu_pkg::CMD_FRAC: res_word_q <= {{(WW-FW){1'b0}}, draw_q[WW-1:WW-FW]};
					xrdu_pkg::CMD_BERN: res_bit_q  <= draw_q[WW-1:WW-FW] < prob_q[FW-1:0];
					default:            res_bit_q  <= res_bit_q;
				endcase
			end
			xrdu_pkg::ST_MOD_WAIT: begin
				if (div_done) begin
					res_int_q <= xrdu_pkg::range_t'(lo_q + xrdu_pkg::range_t'(div_rem[RW-1:0]));
				end
			end
			default: begin
				t5_q <= t5_q;
			end
		endcase
	end

	// output register: loaded from the finished result when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == xrdu_pkg::ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == xrdu_pkg::ST_DONE && slot_free) begin
			out_word_q <= res_word_q;
			out_int_q  <= res_int_q;
			out_bit_q  <= res_bit_q;
			out_err_q  <= res_err_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.word        = out_word_q;
	assign rsp.int_value   = out_int_q;
	assign rsp.bit_value   = out_bit_q;
	assign rsp.range_error = out_err_q;

endmodule

// ===== hw/rtl/xrdu_mul.sv =====
// iterative 64x64 low-half multiplier built from one 32x32 multiplier
`timescale 1ns / 1ps

module xrdu_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  xrdu_pkg::word_t a,
	input  xrdu_pkg::word_t b,
	output logic            done,
	output xrdu_pkg::word_t p
);

	localparam int unsigned HW = xrdu_pkg::HALF_W;

	xrdu_pkg::word_t a_q, b_q, prod_q, acc_q;
	logic [1:0]      cnt_q;
	logic            busy_q, done_q;
	logic [HW-1:0]   op_a, op_b;
	xrdu_pkg::word_t prod_d;

	// partial products: lo*lo, lo*hi, hi*lo
	assign op_a   = cnt_q[1] ? a_q[2*HW-1:HW] : a_q[HW-1:0];
	assign op_b   = (cnt_q == 2'd1) ? b_q[2*HW-1:HW] : b_q[HW-1:0];
	assign prod_d = {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 2'd1;
			busy_q <= (cnt_q != 2'd3);
			done_q <= (cnt_q == 2'd3);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			prod_q <= prod_d;
			case (cnt_q)
				2'd1:    acc_q <= prod_q;
				2'd2,
				2'd3:    acc_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}};
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// ===== hw/rtl/xrdu_div.sv =====
// restoring divider, one quotient bit per cycle, remainder only
`timescale 1ns / 1ps

module xrdu_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  xrdu_pkg::span_t dividend,
	input  xrdu_pkg::span_t divisor,
	output logic            done,
	output xrdu_pkg::span_t rem
);

	localparam int unsigned W  = xrdu_pkg::DIV_W;
	localparam int unsigned CW = xrdu_pkg::DIV_CNT_W;

	logic [W-1:0]  num_q, den_q;
	logic [W:0]    rem_q, trial;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	assign trial = {rem_q[W-1:0], num_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= (cnt_q != CW'(1));
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q[W-1:0];

endmodule
